FILE: hdl/iapr_pkg.sv
package iapr_pkg;

   localparam int COORD_BITS_DEF     = 24;
   localparam int TRIG_FRAC_BITS_DEF = 30;
   localparam int ANGLE_BITS         = 16;

   localparam int DEG_FULL    = 360;
   localparam int DEG_QUARTER = 90;
   localparam int ROM_DEPTH   = DEG_QUARTER + 1;
   localparam int K_BITS      = $clog2(ROM_DEPTH);
   localparam int R_BITS      = $clog2(DEG_FULL);

   localparam int ANGLE_OFFSET = ((2 ** (ANGLE_BITS - 1)) / DEG_FULL + 1) * DEG_FULL;
   localparam int U_BITS       = ANGLE_BITS + 1;
   localparam int RECIP_SHIFT  = 25;
   localparam int RECIP        = (2 ** RECIP_SHIFT) / DEG_FULL;
   localparam int RECIP_BITS   = $clog2(RECIP + 1);
   localparam int MUL_BITS     = U_BITS + RECIP_BITS;
   localparam int Q_BITS       = MUL_BITS - RECIP_SHIFT;

   localparam int NUM_STAGES = 7;

   localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
   localparam logic [63:0] TRIG_STEP = PI_Q60 / 64'd180;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quad_type;

   typedef logic [ROM_DEPTH-1:0][63:0] sin_rom_type;

   // Each entry is sin(k degrees) from a Taylor series in Q0.60, rounded half up
   // to the requested number of fraction bits.
   function automatic sin_rom_type build_sin_rom(int frac);
      sin_rom_type       rom;
      logic [63:0]       ang;
      logic [63:0]       ang2;
      logic [63:0]       term;
      logic signed [63:0] total;
      logic [127:0]      prod;
      logic              done;
      int                k;
      int                n;
      for (k = 0; k < ROM_DEPTH; k++) begin
         ang   = TRIG_STEP * 64'(k);
         prod  = {64'd0, ang} * {64'd0, ang};
         ang2  = prod[123:60];
         term  = ang;
         total = signed'(ang);
         done  = 1'b0;
         for (n = 1; n <= 16; n++) begin
            if (!done) begin
               prod = {64'd0, term} * {64'd0, ang2};
               term = prod[123:60] / 64'((2 * n) * (2 * n + 1));
               if (term == 64'd0) begin
                  done = 1'b1;
               end else if ((n % 2) == 1) begin
                  total = total - signed'(term);
               end else begin
                  total = total + signed'(term);
               end
            end
         end
         if (total < 0) begin
            total = '0;
         end
         rom[k] = (unsigned'(total) + (64'd1 << (59 - frac))) >> (60 - frac);
      end
      return rom;
   endfunction

endpackage

FILE: hdl/integer_angle_point_rotate.sv
// Rotates a signed point (x, y) counter-clockwise about the origin by a signed
// whole-degree angle and returns both coordinates rounded to nearest, ties to even.
// The angle is reduced modulo 360; sine and cosine come from a quarter-wave ROM
// with quadrant symmetry, so multiples of 90 degrees are exact.
// Input: a transaction is taken at every rising edge with start high and busy low.
// Busy is always low, so one point can be taken in every cycle.
// Output: each result is held for one cycle with rsp_strobe high and is taken at
// the edge that ends that cycle; the receiver cannot hold results off.
// Seven register stages lie between the accepting edge and the result: angle
// reciprocal multiply, remainder fix-up, quadrant split, ROM lookup, four
// parallel multipliers, sum and rounding.
// Throughput: one transaction per cycle, set by the fully pipelined datapath.
// Results leave in the order the transactions were taken.
// Reset clears the stage valid bits; transactions in flight are dropped.
module integer_angle_point_rotate
   import iapr_pkg::*;
#(
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [ANGLE_BITS-1:0] req_angle_deg,
   output logic                         rsp_strobe,
   output logic signed [COORD_BITS:0]   rsp_rotated_x,
   output logic signed [COORD_BITS:0]   rsp_rotated_y
);

   localparam int TRIG_W = TRIG_FRAC_BITS + 2;
   localparam int PROD_W = COORD_BITS + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam sin_rom_type SIN_ROM = build_sin_rom(TRIG_FRAC_BITS);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   logic [U_BITS-1:0]   s1_u_ff;
   logic [U_BITS-1:0]   s1_u_in;
   logic [MUL_BITS-1:0] s1_prod_ff;
   logic [MUL_BITS-1:0] s1_prod_in;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   logic signed [COORD_BITS-1:0] s2_x_ff, s2_y_ff;
   logic signed [COORD_BITS-1:0] s3_x_ff, s3_y_ff;
   logic signed [COORD_BITS-1:0] s4_x_ff, s4_y_ff;

   logic [Q_BITS-1:0]   s2_q;
   logic [U_BITS-1:0]   s2_diff;
   logic [R_BITS:0]     s2_rraw;
   logic [R_BITS-1:0]   s2_r_in;
   logic [R_BITS-1:0]   s2_r_ff;

   quad_type            s3_quad_in;
   quad_type            s3_quad_ff;
   logic [K_BITS-1:0]   s3_k_in;
   logic [K_BITS-1:0]   s3_k_ff;

   logic signed [TRIG_W-1:0] s4_s;
   logic signed [TRIG_W-1:0] s4_c;
   logic signed [TRIG_W-1:0] s4_sin_in, s4_cos_in;
   logic signed [TRIG_W-1:0] s4_sin_ff, s4_cos_ff;

   logic signed [PROD_W-1:0] s5_xc_ff, s5_ys_ff, s5_xs_ff, s5_yc_ff;
   logic signed [SUM_W-1:0]  s6_sx_ff, s6_sy_ff;

   logic [COORD_BITS:0] s7_x_in, s7_y_in;
   logic [COORD_BITS:0] s7_x_ff, s7_y_ff;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[NUM_STAGES-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      s1_u_in    = U_BITS'(signed'(req_angle_deg)) + U_BITS'(ANGLE_OFFSET);
      s1_prod_in = MUL_BITS'(s1_u_in) * MUL_BITS'(RECIP);
   end

   always_comb begin
      s2_q    = s1_prod_ff[MUL_BITS-1:RECIP_SHIFT];
      s2_diff = s1_u_ff - U_BITS'(s2_q * DEG_FULL);
      s2_rraw = s2_diff[R_BITS:0];
      if (s2_rraw >= (R_BITS + 1)'(DEG_FULL)) begin
         s2_r_in = R_BITS'(s2_rraw - (R_BITS + 1)'(DEG_FULL));
      end else begin
         s2_r_in = R_BITS'(s2_rraw);
      end
   end

   always_comb begin
      if (s2_r_ff >= R_BITS'(3 * DEG_QUARTER)) begin
         s3_quad_in = QUAD_3;
         s3_k_in    = K_BITS'(s2_r_ff - R_BITS'(3 * DEG_QUARTER));
      end else if (s2_r_ff >= R_BITS'(2 * DEG_QUARTER)) begin
         s3_quad_in = QUAD_2;
         s3_k_in    = K_BITS'(s2_r_ff - R_BITS'(2 * DEG_QUARTER));
      end else if (s2_r_ff >= R_BITS'(DEG_QUARTER)) begin
         s3_quad_in = QUAD_1;
         s3_k_in    = K_BITS'(s2_r_ff - R_BITS'(DEG_QUARTER));
      end else begin
         s3_quad_in = QUAD_0;
         s3_k_in    = K_BITS'(s2_r_ff);
      end
   end

   always_comb begin
      s4_s = signed'({1'b0, SIN_ROM[s3_k_ff][TRIG_FRAC_BITS:0]});
      s4_c = signed'({1'b0, SIN_ROM[K_BITS'(DEG_QUARTER) - s3_k_ff][TRIG_FRAC_BITS:0]});
      case (s3_quad_ff)
         QUAD_0: begin
            s4_sin_in = s4_s;
            s4_cos_in = s4_c;
         end
         QUAD_1: begin
            s4_sin_in = s4_c;
            s4_cos_in = -s4_s;
         end
         QUAD_2: begin
            s4_sin_in = -s4_s;
            s4_cos_in = -s4_c;
         end
         default: begin
            s4_sin_in = -s4_c;
            s4_cos_in = s4_s;
         end
      endcase
   end

   // Round to nearest, ties to even: the result always fits in COORD_BITS+1 bits.
   always_comb begin
      s7_x_in = s6_sx_ff[TRIG_FRAC_BITS+COORD_BITS:TRIG_FRAC_BITS]
              + (COORD_BITS + 1)'(s6_sx_ff[TRIG_FRAC_BITS-1]
                && ((|s6_sx_ff[TRIG_FRAC_BITS-2:0]) || s6_sx_ff[TRIG_FRAC_BITS]));
      s7_y_in = s6_sy_ff[TRIG_FRAC_BITS+COORD_BITS:TRIG_FRAC_BITS]
              + (COORD_BITS + 1)'(s6_sy_ff[TRIG_FRAC_BITS-1]
                && ((|s6_sy_ff[TRIG_FRAC_BITS-2:0]) || s6_sy_ff[TRIG_FRAC_BITS]));
   end

   always_ff @(posedge clock) begin
      s1_u_ff    <= s1_u_in;
      s1_prod_ff <= s1_prod_in;
      s1_x_ff    <= req_point_x;
      s1_y_ff    <= req_point_y;

      s2_r_ff <= s2_r_in;
      s2_x_ff <= s1_x_ff;
      s2_y_ff <= s1_y_ff;

      s3_quad_ff <= s3_quad_in;
      s3_k_ff    <= s3_k_in;
      s3_x_ff    <= s2_x_ff;
      s3_y_ff    <= s2_y_ff;

      s4_sin_ff <= s4_sin_in;
      s4_cos_ff <= s4_cos_in;
      s4_x_ff   <= s3_x_ff;
      s4_y_ff   <= s3_y_ff;

      s5_xc_ff <= s4_x_ff * s4_cos_ff;
      s5_ys_ff <= s4_y_ff * s4_sin_ff;
      s5_xs_ff <= s4_x_ff * s4_sin_ff;
      s5_yc_ff <= s4_y_ff * s4_cos_ff;

      s6_sx_ff <= SUM_W'(s5_xc_ff) - SUM_W'(s5_ys_ff);
      s6_sy_ff <= SUM_W'(s5_xs_ff) + SUM_W'(s5_yc_ff);

      s7_x_ff <= s7_x_in;
      s7_y_ff <= s7_y_in;
   end

   assign rsp_strobe    = valid_ff[NUM_STAGES-1];
   assign rsp_rotated_x = signed'(s7_x_ff);
   assign rsp_rotated_y = signed'(s7_y_ff);

   a_remainder_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (s2_r_ff < R_BITS'(DEG_FULL)))
      else $error("angle remainder out of range");

   a_offset_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (s3_k_ff < K_BITS'(DEG_QUARTER)))
      else $error("quadrant offset out of range");

   a_right_angle_exact : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && (s3_k_ff == '0)) |=> ((s4_sin_ff == '0) || (s4_cos_ff == '0)))
      else $error("right angle did not give a zero sine or cosine");

   a_strobe_follows_start : assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-2] |=> rsp_strobe)
      else $error("pipeline lost a transaction");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import iapr_pkg::*;

   localparam int CW   = COORD_BITS_DEF;
   localparam int FRAC = TRIG_FRAC_BITS_DEF;
   localparam int RANDOM_POINTS = 1600;
   localparam int DRAIN_CYCLES  = 12;

   typedef struct {
      logic signed [CW:0] rotated_x;
      logic signed [CW:0] rotated_y;
   } rotation_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [CW-1:0]         req_point_x;
   logic signed [CW-1:0]         req_point_y;
   logic signed [ANGLE_BITS-1:0] req_angle_deg;
   logic                         rsp_strobe;
   logic signed [CW:0]           rsp_rotated_x;
   logic signed [CW:0]           rsp_rotated_y;

   rotation_type pending_rotations[$];
   logic [63:0]  quarter_sine[0:DEG_QUARTER];
   int           idle_percent;
   int           mismatches;

   integer_angle_point_rotate dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_angle_deg (req_angle_deg),
      .rsp_strobe    (rsp_strobe),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] sine_degrees(int k);
      logic [63:0]        arg;
      logic [63:0]        arg_sq;
      logic [63:0]        term;
      logic signed [63:0] acc;
      int                 n;
      arg    = (PI_Q60 / 64'd180) * 64'(k);
      arg_sq = q60_mul(arg, arg);
      term   = arg;
      acc    = signed'(arg);
      for (n = 1; n <= 16; n++) begin
         term = q60_mul(term, arg_sq) / 64'((2 * n) * (2 * n + 1));
         if (term == 64'd0) break;
         if (n % 2 == 1) acc = acc - signed'(term);
         else acc = acc + signed'(term);
      end
      if (acc < 0) acc = 0;
      return (unsigned'(acc) + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
   endfunction

   function automatic logic signed [CW:0] round_even(logic signed [63:0] v);
      logic signed [63:0] q;
      logic [63:0]        rem;
      logic [63:0]        half;
      q    = v >>> FRAC;
      rem  = v & ((64'd1 << FRAC) - 64'd1);
      half = 64'd1 << (FRAC - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'sd1;
      return q[CW:0];
   endfunction

   function automatic rotation_type rotate_point(logic signed [CW-1:0] x,
                                                 logic signed [CW-1:0] y,
                                                 logic signed [ANGLE_BITS-1:0] a);
      rotation_type       r;
      int                 reduced;
      int                 k;
      quad_type           quad;
      longint             xs;
      longint             ys;
      longint             s;
      longint             c;
      longint             sn;
      longint             cs;
      reduced = ((int'(a) % DEG_FULL) + DEG_FULL) % DEG_FULL;
      quad    = quad_type'(reduced / DEG_QUARTER);
      k       = reduced % DEG_QUARTER;
      s       = longint'(quarter_sine[k]);
      c       = longint'(quarter_sine[DEG_QUARTER - k]);
      xs      = x;
      ys      = y;
      case (quad)
         QUAD_0: begin sn = s;  cs = c;  end
         QUAD_1: begin sn = c;  cs = -s; end
         QUAD_2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
      r.rotated_x = round_even(xs * cs - ys * sn);
      r.rotated_y = round_even(xs * sn + ys * cs);
      return r;
   endfunction

   // Entered and left at a falling edge; start stays high between back-to-back items.
   task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [ANGLE_BITS-1:0] a);
      logic taken;
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_point_x   <= x;
      req_point_y   <= y;
      req_angle_deg <= a;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         if (taken) pending_rotations.push_back(rotate_point(x, y, a));
         @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_rotations.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [CW-1:0] random_coord();
      case ($urandom_range(4))
         0: return CW'($urandom_range(2000)) - CW'(1000);
         1: case ($urandom_range(3))
               0: return {1'b0, {(CW-1){1'b1}}};
               1: return {1'b1, {(CW-1){1'b0}}};
               2: return '0;
               default: return '1;
            endcase
         default: return CW'($urandom());
      endcase
   endfunction

   function automatic logic signed [ANGLE_BITS-1:0] random_angle();
      case ($urandom_range(3))
         0: return ANGLE_BITS'($urandom_range(1440)) - ANGLE_BITS'(720);
         1: return ANGLE_BITS'(DEG_QUARTER * ($urandom_range(8))) - ANGLE_BITS'(360);
         default: return ANGLE_BITS'($urandom());
      endcase
   endfunction

   task automatic test_coordinate_extremes();
      logic signed [CW-1:0] vmax;
      logic signed [CW-1:0] vmin;
      vmax = {1'b0, {(CW-1){1'b1}}};
      vmin = {1'b1, {(CW-1){1'b0}}};
      send_point(vmax, vmax, 16'sd45);
      send_point(vmin, vmin, 16'sd45);
      send_point(vmax, vmin, 16'sd135);
      send_point(vmin, vmax, 16'sd315);
      send_point(vmin, vmin, 16'sd0);
      send_point(vmax, vmax, 16'sd180);
      send_point('0, '0, 16'sd37);
      send_point(-24'sd1, 24'sd1, 16'sd1);
   endtask

   task automatic test_angle_reduction();
      send_point(24'sd1000, 24'sd250, 16'sd90);
      send_point(24'sd1000, 24'sd250, 16'sd180);
      send_point(24'sd1000, 24'sd250, 16'sd270);
      send_point(24'sd1000, 24'sd250, -16'sd90);
      send_point(24'sd1000, 24'sd250, 16'sd360);
      send_point(24'sd1000, 24'sd250, -16'sd360);
      send_point(24'sd1000, 24'sd250, 16'sd359);
      send_point(24'sd1000, 24'sd250, 16'sd89);
      send_point(24'sd1000, 24'sd250, 16'sd91);
      send_point(24'sd77777, -24'sd4321, 16'sh7FFF);
      send_point(24'sd77777, -24'sd4321, 16'sh8000);
      send_point(24'sd3, 24'sd5, 16'sd30);
      send_point(24'sd3, 24'sd5, 16'sd60);
   endtask

   task automatic test_drain_pause();
      wait_for_drain();
      @(negedge clock);
      send_point(random_coord(), random_coord(), random_angle());
      wait_for_drain();
   endtask

   task automatic test_random_points();
      int i;
      for (i = 0; i < RANDOM_POINTS; i++) begin
         idle_percent = (i >= 400 && i < 700) ? 0 : 36;
         if (i == 1000) test_drain_pause();
         send_point(random_coord(), random_coord(), random_angle());
      end
   endtask

   always @(posedge clock) begin : check_result
      rotation_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rotations.size() == 0) begin
            $error("unexpected result: rotated_x %0d rotated_y %0d",
                   rsp_rotated_x, rsp_rotated_y);
            mismatches++;
         end else begin
            want = pending_rotations.pop_front();
            if (rsp_rotated_x !== want.rotated_x) begin
               $error("rotated_x: expected %0d, actual %0d", want.rotated_x, rsp_rotated_x);
               mismatches++;
            end
            if (rsp_rotated_y !== want.rotated_y) begin
               $error("rotated_y: expected %0d, actual %0d", want.rotated_y, rsp_rotated_y);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int k;
      reset         = 1'b1;
      start         = 1'b0;
      req_point_x   = '0;
      req_point_y   = '0;
      req_angle_deg = '0;
      mismatches    = 0;
      idle_percent  = 36;
      for (k = 0; k <= DEG_QUARTER; k++) quarter_sine[k] = sine_degrees(k);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_coordinate_extremes();
      test_angle_reduction();
      test_drain_pause();
      test_random_points();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_rotations.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
hdl/iapr_pkg.sv
hdl/integer_angle_point_rotate.sv
bench/testbench.sv
